### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

### design/aars_pkg.sv
// Shared types, codes and reset values of the auto-repeat scroll keeper.
package aars_pkg;

    typedef logic [2:0]  cfg_idx_t;
    typedef logic [15:0] cfg_data_t;
    typedef logic [15:0] line_t;
    typedef logic [31:0] ms_t;
    typedef logic [15:0] delay_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_TOTAL_LINES   = 3'd0;
    localparam cfg_idx_t REG_VISIBLE_LINES = 3'd1;
    localparam cfg_idx_t REG_DEAD_ZONE     = 3'd2;
    localparam cfg_idx_t REG_INITIAL_DELAY = 3'd3;
    localparam cfg_idx_t REG_REPEAT_DELAY  = 3'd4;
    localparam cfg_idx_t REG_ACCEL_DELAY   = 3'd5;
    localparam cfg_idx_t REG_FAST_STEP     = 3'd6;

    // Item opcodes.
    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // Button codes.
    localparam logic [1:0] BTN_BACK  = 2'd0;
    localparam logic [1:0] BTN_DOWN  = 2'd1;
    localparam logic [1:0] BTN_UP    = 2'd2;
    localparam logic [1:0] BTN_OTHER = 2'd3;

    // Register reset values.
    localparam line_t       TOTAL_LINES_RST   = 16'd0;
    localparam logic [7:0]  VISIBLE_LINES_RST = 8'd15;
    localparam logic [14:0] DEAD_ZONE_RST     = 15'd8000;
    localparam delay_t      INITIAL_DELAY_RST = 16'd180;
    localparam delay_t      REPEAT_DELAY_RST  = 16'd40;
    localparam delay_t      ACCEL_DELAY_RST   = 16'd600;
    localparam logic [2:0]  FAST_STEP_RST     = 3'd3;

endpackage

### design/aars_if.sv
// Item channels of the scroll keeper: input events and scroll results.
interface aars_event_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic signed [15:0] axis_value;
    aars_pkg::ms_t     now_ms;
    logic [1:0]        button;

    modport source(output valid, opcode, axis_value, now_ms, button, input ready);
    modport sink(input valid, opcode, axis_value, now_ms, button, output ready);
endinterface

interface aars_result_if;
    logic                valid;
    logic                ready;
    aars_pkg::line_t     scroll_offset;
    logic                back_request;

    modport source(output valid, scroll_offset, back_request, input ready);
    modport sink(input valid, scroll_offset, back_request, output ready);
endinterface

### design/axis_autorepeat_scroll_top.sv
// Top level of the axis auto-repeat scroll keeper.
// An accepted item waits in the input register; its result is registered when the item advances.
// Throughput: one item per cycle unless results stall; the input register refills as the result register drains.
// The offset, hold and timing registers update in the single compute stage between them.
// Reset clears the offset, the hold flag and both time stamps, and loads register defaults.
`include "assert_macros.svh"

module axis_autorepeat_scroll_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  aars_pkg::cfg_idx_t   cfg_index,
    input  aars_pkg::cfg_data_t  cfg_data,
    aars_event_if.sink           events,
    aars_result_if.source        results
);
    import aars_pkg::*;

    // Configuration registers.
    line_t       total_lines_reg;
    logic [7:0]  visible_lines_reg;
    logic [14:0] dead_zone_reg;
    delay_t      initial_delay_reg;
    delay_t      repeat_delay_reg;
    delay_t      accel_delay_reg;
    logic [2:0]  fast_step_reg;

    // Scroll state.
    line_t offset_reg, offset_next;
    logic  hold_active_reg, hold_active_next;
    ms_t   hold_start_reg, hold_start_next;
    ms_t   last_repeat_reg, last_repeat_next;

    // Input register.
    logic        in_valid_reg;
    logic        in_opcode_reg;
    logic [15:0] in_axis_reg;
    ms_t         in_now_reg;
    logic [1:0]  in_button_reg;

    // Result register.
    logic  out_valid_reg, out_valid_next;
    line_t out_offset_reg;
    logic  out_back_reg;

    logic  accept;
    logic  advance;
    logic  back_next;
    logic  neg;
    line_t mag;
    logic  outside;
    line_t limit;
    logic  first;
    delay_t wait_ms;
    logic  due;
    ms_t   since_last;
    ms_t   start_eff;
    ms_t   held_ms;
    logic [2:0] step;
    logic  do_down, do_up;
    line_t amount;
    line_t room;
    line_t down_val, up_val;

    assign advance      = in_valid_reg && (!out_valid_reg || results.ready);
    assign events.ready = !in_valid_reg || advance;
    assign accept       = events.valid && events.ready;

    assign results.valid         = out_valid_reg;
    assign results.scroll_offset = out_offset_reg;
    assign results.back_request  = out_back_reg;

    always_comb
    begin
        neg     = in_axis_reg[15];
        mag     = neg ? (~in_axis_reg + 16'd1) : in_axis_reg;
        outside = mag > {1'b0, dead_zone_reg};
        limit   = (total_lines_reg > {8'd0, visible_lines_reg})
                  ? (total_lines_reg - {8'd0, visible_lines_reg}) : 16'd0;

        first      = !hold_active_reg;
        wait_ms    = (last_repeat_reg == hold_start_reg) ? initial_delay_reg : repeat_delay_reg;
        since_last = in_now_reg - last_repeat_reg;
        due        = first || (since_last >= {16'd0, wait_ms});
        // A new hold starts now, so its held time is zero.
        start_eff  = first ? in_now_reg : hold_start_reg;
        held_ms    = in_now_reg - start_eff;
        step       = (held_ms > {16'd0, accel_delay_reg}) ? fast_step_reg : 3'd1;

        hold_active_next = hold_active_reg;
        hold_start_next  = hold_start_reg;
        last_repeat_next = last_repeat_reg;
        back_next        = 1'b0;
        do_down          = 1'b0;
        do_up            = 1'b0;
        amount           = 16'd1;

        case (in_opcode_reg)
            OP_BUTTON:
            begin
                case (in_button_reg)
                    BTN_BACK:  back_next = 1'b1;
                    BTN_DOWN:  do_down   = 1'b1;
                    BTN_UP:    do_up     = 1'b1;
                    default:   back_next = 1'b0;
                endcase
            end
            default:
            begin
                if (outside)
                begin
                    hold_active_next = 1'b1;
                    if (first)
                    begin
                        hold_start_next = in_now_reg;
                    end
                    if (due)
                    begin
                        last_repeat_next = in_now_reg;
                        amount           = {13'd0, step};
                        do_up            = neg;
                        do_down          = !neg;
                    end
                end
                else
                begin
                    hold_active_next = 1'b0;
                end
            end
        endcase

        // Down stops at the limit and leaves an offset beyond it alone.
        room     = limit - offset_reg;
        down_val = (offset_reg < limit)
                   ? (offset_reg + ((amount < room) ? amount : room)) : offset_reg;
        up_val   = (offset_reg > amount) ? (offset_reg - amount) : 16'd0;

        if (do_down)
        begin
            offset_next = down_val;
        end
        else if (do_up)
        begin
            offset_next = up_val;
        end
        else
        begin
            offset_next = offset_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_lines_reg   <= TOTAL_LINES_RST;
            visible_lines_reg <= VISIBLE_LINES_RST;
            dead_zone_reg     <= DEAD_ZONE_RST;
            initial_delay_reg <= INITIAL_DELAY_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            accel_delay_reg   <= ACCEL_DELAY_RST;
            fast_step_reg     <= FAST_STEP_RST;
            offset_reg        <= 16'd0;
            hold_active_reg   <= 1'b0;
            hold_start_reg    <= 32'd0;
            last_repeat_reg   <= 32'd0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;

            if (advance)
            begin
                offset_reg      <= offset_next;
                hold_active_reg <= hold_active_next;
                hold_start_reg  <= hold_start_next;
                last_repeat_reg <= last_repeat_next;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOTAL_LINES:
                    begin
                        total_lines_reg <= cfg_data;
                        offset_reg      <= 16'd0;
                    end
                    REG_VISIBLE_LINES: visible_lines_reg <= cfg_data[7:0];
                    REG_DEAD_ZONE:     dead_zone_reg     <= cfg_data[14:0];
                    REG_INITIAL_DELAY: initial_delay_reg <= cfg_data;
                    REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                    REG_ACCEL_DELAY:   accel_delay_reg   <= cfg_data;
                    REG_FAST_STEP:     fast_step_reg     <= cfg_data[2:0];
                    default:           fast_step_reg     <= fast_step_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_opcode_reg <= events.opcode;
            in_axis_reg   <= events.axis_value;
            in_now_reg    <= events.now_ms;
            in_button_reg <= events.button;
        end
        if (advance)
        begin
            out_offset_reg <= offset_next;
            out_back_reg   <= back_next;
        end
    end

    `ASSERT_SAME(a_back_keeps_offset, advance && in_opcode_reg == OP_BUTTON && in_button_reg == BTN_BACK, offset_next == offset_reg)
    `ASSERT_NEXT(a_advance_loads_result, advance, out_valid_reg)
    `ASSERT_NEXT(a_pending_item_kept, in_valid_reg && !advance, in_valid_reg)
    `ASSERT_NEXT(a_release_ends_hold, advance && in_opcode_reg == OP_POLL && !outside, !hold_active_reg)

endmodule

### tb/testbench.sv
// Self-checking testbench of the axis auto-repeat scroll keeper.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aars_pkg::*;

    localparam int       CYCLE_LIMIT    = 300000;
    localparam int       RX_HOLD_CYCLES = 90;
    localparam int       MAX_REPORTS    = 40;
    localparam cfg_idx_t REG_UNUSED     = 3'd7;

    typedef struct {
        logic               opcode;
        logic signed [15:0] axis_value;
        ms_t                now_ms;
        logic [1:0]         button;
    } scroll_event_t;

    typedef struct {
        line_t scroll_offset;
        logic  back_request;
    } scroll_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_data_t cfg_data;

    aars_event_if  evt_ch();
    aars_result_if res_ch();

    axis_autorepeat_scroll_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (evt_ch),
        .results   (res_ch)
    );

    // Predicted register file and scroll state.
    line_t       cfg_total;
    logic [7:0]  cfg_visible;
    logic [14:0] cfg_dead;
    delay_t      cfg_init;
    delay_t      cfg_rep;
    delay_t      cfg_accel;
    logic [2:0]  cfg_fast;
    line_t       pos_offset;
    logic        hold_on;
    ms_t         hold_t0;
    ms_t         last_rep_t;

    scroll_result_t pending_scroll_q[$];

    int  error_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  cfg_writes = 0;
    int  holds_run = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    ms_t clock_ms = 32'd1000;

    bit  rx_hold_req = 1'b0;
    int  rx_hold_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run stopped by timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge clk) begin
        scroll_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_scroll_q.size() == 0) begin
                flag_mismatch($sformatf("result offset %0d with no item pending",
                                        res_ch.scroll_offset));
            end
            else begin
                want = pending_scroll_q.pop_front();
                results_checked++;
                if (res_ch.scroll_offset !== want.scroll_offset)
                    flag_mismatch($sformatf("result %0d: offset %0d, expected %0d",
                                            results_checked, res_ch.scroll_offset,
                                            want.scroll_offset));
                if (res_ch.back_request !== want.back_request)
                    flag_mismatch($sformatf("result %0d: back_request %b, expected %b",
                                            results_checked, res_ch.back_request,
                                            want.back_request));
            end
        end
    end

    // Receiver: random stall patterns, plus a long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_left = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            if (rx_hold_left > 0) begin
                res_ch.ready = 1'b0;
                rx_hold_left--;
            end
            else begin
                case (rx_mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = ($urandom_range(0, 3) != 0);
                    2: res_ch.ready = ($urandom_range(0, 3) == 0);
                    default: res_ch.ready = ((cycles % 5) < 3);
                endcase
            end
        end
    end

    task automatic reset_model();
        cfg_total   = TOTAL_LINES_RST;
        cfg_visible = VISIBLE_LINES_RST;
        cfg_dead    = DEAD_ZONE_RST;
        cfg_init    = INITIAL_DELAY_RST;
        cfg_rep     = REPEAT_DELAY_RST;
        cfg_accel   = ACCEL_DELAY_RST;
        cfg_fast    = FAST_STEP_RST;
        pos_offset  = '0;
        hold_on     = 1'b0;
        hold_t0     = '0;
        last_rep_t  = '0;
    endtask

    function automatic int scroll_limit();
        return (cfg_total > cfg_visible) ? int'(cfg_total) - int'(cfg_visible) : 0;
    endfunction

    function automatic void scroll_down(int lines);
        int lim;
        int room;
        lim = scroll_limit();
        if (int'(pos_offset) < lim) begin
            room = lim - int'(pos_offset);
            pos_offset = line_t'(int'(pos_offset) + ((lines < room) ? lines : room));
        end
    endfunction

    function automatic void scroll_up(int lines);
        pos_offset = (int'(pos_offset) > lines) ? line_t'(int'(pos_offset) - lines) : '0;
    endfunction

    // Advances the predicted state by one item and returns its result.
    function automatic scroll_result_t predict_scroll(scroll_event_t ev);
        scroll_result_t r;
        int  mag;
        int  lines;
        bit  due;
        ms_t elapsed;
        ms_t needed;
        r.back_request = 1'b0;
        if (ev.opcode == OP_BUTTON) begin
            case (ev.button)
                BTN_BACK: r.back_request = 1'b1;
                BTN_DOWN: scroll_down(1);
                BTN_UP:   scroll_up(1);
                default: ;
            endcase
        end
        else begin
            mag = (ev.axis_value < 0) ? -int'(ev.axis_value) : int'(ev.axis_value);
            if (mag > int'(cfg_dead)) begin
                if (!hold_on) begin
                    hold_on = 1'b1;
                    hold_t0 = ev.now_ms;
                    due = 1'b1;
                end
                else begin
                    // The first repeat of a hold waits the initial delay.
                    needed = (last_rep_t == hold_t0) ? ms_t'(cfg_init) : ms_t'(cfg_rep);
                    elapsed = ev.now_ms - last_rep_t;
                    due = (elapsed >= needed);
                end
                if (due) begin
                    elapsed = ev.now_ms - hold_t0;
                    lines = (elapsed > ms_t'(cfg_accel)) ? int'(cfg_fast) : 1;
                    if (ev.axis_value < 0)
                        scroll_up(lines);
                    else
                        scroll_down(lines);
                    last_rep_t = ev.now_ms;
                end
            end
            else begin
                hold_on = 1'b0;
            end
        end
        r.scroll_offset = pos_offset;
        return r;
    endfunction

    // Sends one item; called and returns at a falling edge.
    task automatic send_item(scroll_event_t ev);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                evt_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        evt_ch.valid      = 1'b1;
        evt_ch.opcode     = ev.opcode;
        evt_ch.axis_value = ev.axis_value;
        evt_ch.now_ms     = ev.now_ms;
        evt_ch.button     = ev.button;
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        pending_scroll_q.insert(pending_scroll_q.size(), predict_scroll(ev));
        items_sent++;
        @(negedge clk);
    endtask

    // Poll item; the button field carries noise.
    task automatic poll(int axis, ms_t now);
        scroll_event_t ev;
        ev.opcode     = OP_POLL;
        ev.axis_value = axis[15:0];
        ev.now_ms     = now;
        ev.button     = 2'($urandom_range(0, 3));
        send_item(ev);
    endtask

    // Button item; axis and time carry noise.
    task automatic press(logic [1:0] btn);
        scroll_event_t ev;
        ev.opcode     = OP_BUTTON;
        ev.axis_value = 16'($urandom);
        ev.now_ms     = $urandom;
        ev.button     = btn;
        send_item(ev);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        evt_ch.valid = 1'b0;
        burst_left = 0;
        while (pending_scroll_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        case (idx)
            REG_TOTAL_LINES: begin
                cfg_total  = value;
                pos_offset = '0;
            end
            REG_VISIBLE_LINES: cfg_visible = value[7:0];
            REG_DEAD_ZONE:     cfg_dead    = value[14:0];
            REG_INITIAL_DELAY: cfg_init    = value;
            REG_REPEAT_DELAY:  cfg_rep     = value;
            REG_ACCEL_DELAY:   cfg_accel   = value;
            REG_FAST_STEP:     cfg_fast    = value[2:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(int total, int vis, int dead, int init, int rep,
                             int accel, int fast);
        write_reg(REG_TOTAL_LINES, cfg_data_t'(total));
        write_reg(REG_VISIBLE_LINES, cfg_data_t'(vis));
        write_reg(REG_DEAD_ZONE, cfg_data_t'(dead));
        write_reg(REG_INITIAL_DELAY, cfg_data_t'(init));
        write_reg(REG_REPEAT_DELAY, cfg_data_t'(rep));
        write_reg(REG_ACCEL_DELAY, cfg_data_t'(accel));
        write_reg(REG_FAST_STEP, cfg_data_t'(fast));
    endtask

    // Time step between polls, biased to land on the delay thresholds.
    function automatic ms_t next_step();
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, 3);
            2, 3: return ms_t'(int'(cfg_rep) + $urandom_range(0, 2) - 1);
            4:    return ms_t'(int'(cfg_init) + $urandom_range(0, 2) - 1);
            5:    return ms_t'(int'(cfg_accel) + $urandom_range(0, 2) - 1);
            6, 7, 8: return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    // One held-axis sequence with random content, mostly closed by a release.
    task automatic run_hold();
        int  polls;
        int  mag;
        int  dz;
        bit  upward;
        polls = $urandom_range(2, 14);
        upward = 1'($urandom_range(0, 1));
        dz = int'(cfg_dead);
        holds_run++;
        if ($urandom_range(0, 7) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        repeat (polls) begin
            clock_ms += next_step();
            if ($urandom_range(0, 7) == 0)
                press(2'($urandom_range(0, 3)));
            mag = $urandom_range(32768, dz + 1);
            if (!upward && mag > 32767)
                mag = 32767;
            poll(upward ? -mag : mag, clock_ms);
        end
        if ($urandom_range(0, 5) != 0) begin
            clock_ms += $urandom_range(0, 50);
            poll(int'($urandom_range(0, 2 * dz)) - dz, clock_ms);
        end
    endtask

    task automatic run_mixed(int count);
        int stop_at;
        scroll_event_t ev;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                run_hold();
            end
            else begin
                ev.opcode     = 1'($urandom_range(0, 1));
                ev.axis_value = 16'($urandom);
                ev.now_ms     = ($urandom_range(0, 1) != 0) ? $urandom : clock_ms;
                ev.button     = 2'($urandom_range(0, 3));
                send_item(ev);
            end
        end
    endtask

    task automatic test_buttons_and_hold();
        write_reg(REG_TOTAL_LINES, 100);
        write_reg(REG_VISIBLE_LINES, 10);
        press(BTN_DOWN);
        press(BTN_UP);
        press(BTN_UP);
        press(BTN_BACK);
        press(BTN_OTHER);
        poll(32767, 1000);
        poll(20000, 1100);
        poll(9000, 1180);
        poll(32767, 1219);
        poll(32767, 1220);
        press(BTN_DOWN);
        poll(32767, 1700);
        poll(8000, 1701);
        poll(-8000, 1702);
        // A hold that starts just before the time stamp wraps.
        poll(-32768, 32'hFFFF_FFF0);
        poll(-8001, 32'h0000_00A4);
        poll(0, 32'h0000_00A5);
        drain();
    endtask

    task automatic test_limit_changes();
        write_all(20, 5, 0, 0, 0, 0, 7);
        poll(1, 10);
        poll(1, 11);
        poll(1, 12);
        press(BTN_DOWN);
        drain();
        // Growing the window leaves the offset above the new limit.
        write_reg(REG_VISIBLE_LINES, 12);
        write_reg(REG_UNUSED, 16'hFFFF);
        press(BTN_DOWN);
        poll(-1, 13);
        press(BTN_UP);
        drain();
        write_reg(REG_FAST_STEP, 0);
        write_reg(REG_VISIBLE_LINES, 0);
        poll(-5, 14);
        press(BTN_DOWN);
        drain();
    endtask

    task automatic test_config_extremes();
        write_all(0, 255, 0, 0, 0, 0, 7);
        run_mixed(60);
        drain();
        write_all(65535, 1, 32767, 65535, 65535, 65535, 1);
        run_mixed(60);
        drain();
        write_all(65535, 0, 0, 1, 1, 2, 7);
        run_mixed(60);
        drain();
    endtask

    task automatic test_random_phases();
        repeat (11) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_TOTAL_LINES, cfg_data_t'(($urandom_range(0, 7) == 0) ? $urandom :
                          (($urandom_range(0, 1) != 0) ? $urandom_range(0, 40)
                                                        : $urandom_range(0, 400))));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_VISIBLE_LINES, cfg_data_t'(($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 255) : $urandom_range(1, 60)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DEAD_ZONE, cfg_data_t'(($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 32767) : $urandom_range(0, 16000)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_INITIAL_DELAY, cfg_data_t'(($urandom_range(0, 9) == 0) ?
                          $urandom : $urandom_range(0, 250)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_REPEAT_DELAY, cfg_data_t'(($urandom_range(0, 9) == 0) ?
                          $urandom : $urandom_range(0, 80)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ACCEL_DELAY, cfg_data_t'(($urandom_range(0, 9) == 0) ?
                          $urandom : $urandom_range(0, 800)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_FAST_STEP, cfg_data_t'($urandom_range(0, 7)));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNUSED, cfg_data_t'($urandom));
            run_mixed(150);
            drain();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_all(300, 20, 4000, 30, 10, 100, 4);
        gaps_on = 1'b0;
        rx_hold_req = 1'b1;
        run_mixed(30);
        drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_TOTAL_LINES;
        cfg_data          = '0;
        evt_ch.valid      = 1'b0;
        evt_ch.opcode     = OP_POLL;
        evt_ch.axis_value = '0;
        evt_ch.now_ms     = '0;
        evt_ch.button     = BTN_OTHER;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_buttons_and_hold();
        test_limit_changes();
        test_config_extremes();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (4) @(negedge clk);
        if (pending_scroll_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_scroll_q.size()));
        $display("Sent %0d items (%0d held-axis sequences) over %0d register writes;",
                 items_sent, holds_run, cfg_writes);
        $display("checked %0d results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
